FILE: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace core.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;   // pattern and replacement lengths, 0..15 before clamping
  localparam int WORD_W    = 64;  // packed pattern / replacement word
  localparam int REP_IDX_W = 3;   // byte select inside the packed word
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REP,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]  plen;       // clamped pattern length
    logic [LEN_W-1:0]  rlen;       // clamped replacement length
    logic [WORD_W-1:0] pat;
    logic [WORD_W-1:0] rep;
    logic              pat_clear;  // pattern rewritten, drop held bytes
  } cfg_t;

  typedef struct packed {
    logic match;  // held bytes are a prefix of the pattern
    logic full;   // and cover the whole pattern
  } cmp_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              bvalid;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

FILE: rtl/core/stream_find_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Byte stream find-and-replace with a configurable pattern and replacement.
// ----------------------------------------------------------------------------
// Each input item is one text byte. Bytes matching a prefix of the pattern are
// held; a full match emits the replacement and counts it, a mismatch emits the
// oldest held byte and rechecks the rest. s_tready is low while an item is
// worked on, also through any output stall, since a single sequencer drives
// one shared prefix comparator and emits at most one result per cycle while
// the output is not stalled. Results pass a one-item lookahead register so the
// last result of each input byte can be flagged; a text end with nothing to
// emit yields a bare end mark.
module stream_find_replace_core #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfr_pkg::WORD_W-1:0]          cfg_data,
  // text in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] in_byte
  input  logic                                s_tlast,  // in_last
  // text out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,  // [7:0] out_byte, [8] run_last,
                                                        // [24:9] replace_count, rest zero
  output logic                                m_tuser,  // byte_valid
  output logic                                m_tlast   // stream_end
);

  sfr_pkg::cfg_t                              cfg;
  sfr_pkg::cmp_t                              cmp;
  sfr_pkg::result_t                           out_res;
  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] hold;
  logic [sfr_pkg::LEN_W-1:0]                  len;
  logic                                       out_run_last;
  logic                                       out_end;

  sfr_cfg #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfr_cmp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cmp (
    .hold (hold),
    .len  (len),
    .plen (cfg.plen),
    .pat  (cfg.pat),
    .res  (cmp)
  );

  sfr_seq #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmp          (cmp),
    .hold         (hold),
    .len          (len),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .in_byte      (s_tdata),
    .in_last      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_res      (out_res),
    .out_run_last (out_run_last),
    .out_end      (out_end)
  );

  assign m_tdata = {7'd0, out_res.count, out_run_last, out_res.data};
  assign m_tuser = out_res.bvalid;
  assign m_tlast = out_end;

endmodule

FILE: rtl/core/sfr_cfg.sv
// ----------------------------------------------------------------------------
// sfr_cfg
// Configuration register file with length clamping.
// ----------------------------------------------------------------------------
module sfr_cfg #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::WORD_W-1:0]     cfg_data,
  output sfr_pkg::cfg_t                  cfg
);

  logic [sfr_pkg::LEN_W-1:0]  pattern_length;
  logic [sfr_pkg::WORD_W-1:0] pattern_bytes;
  logic [sfr_pkg::LEN_W-1:0]  replacement_length;
  logic [sfr_pkg::WORD_W-1:0] replacement_bytes;
  logic                       wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_bytes      <= '0;
      replacement_length <= '0;
      replacement_bytes  <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        sfr_pkg::REG_PATTERN_LENGTH:
          pattern_length <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_PATTERN_BYTES:
          pattern_bytes <= cfg_data;
        sfr_pkg::REG_REPLACEMENT_LENGTH:
          replacement_length <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:
          replacement_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.plen = (pattern_length > sfr_pkg::LEN_W'(MAX_PATTERN)) ?
               sfr_pkg::LEN_W'(MAX_PATTERN) : pattern_length;
    cfg.rlen = (replacement_length > sfr_pkg::LEN_W'(MAX_REPLACEMENT)) ?
               sfr_pkg::LEN_W'(MAX_REPLACEMENT) : replacement_length;
    cfg.pat  = pattern_bytes;
    cfg.rep  = replacement_bytes;
    cfg.pat_clear = wr && ((cfg_index == sfr_pkg::REG_PATTERN_LENGTH) ||
                           (cfg_index == sfr_pkg::REG_PATTERN_BYTES));
  end

endmodule

FILE: rtl/core/sfr_cmp.sv
// ----------------------------------------------------------------------------
// sfr_cmp
// Shared prefix comparator: held bytes against the pattern, one check a cycle.
// ----------------------------------------------------------------------------
module sfr_cmp #(
  parameter int MAX_PATTERN = 8
) (
  input  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] hold,
  input  logic [sfr_pkg::LEN_W-1:0]                   len,
  input  logic [sfr_pkg::LEN_W-1:0]                   plen,
  input  logic [sfr_pkg::WORD_W-1:0]                  pat,
  output sfr_pkg::cmp_t                               res
);

  logic [MAX_PATTERN-1:0] eq;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      // entries beyond the held length do not take part
      eq[i] = (sfr_pkg::LEN_W'(i) >= len) ||
              (hold[i] == pat[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]);
    end
    res.match = (plen != '0) && (len <= plen) && (&eq);
    res.full  = res.match && (len == plen);
  end

endmodule

FILE: rtl/core/sfr_seq.sv
// ----------------------------------------------------------------------------
// sfr_seq
// Sequencer: holds prefix bytes, drives the comparator, emits results.
// ----------------------------------------------------------------------------
module sfr_seq #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  sfr_pkg::cfg_t                               cfg,
  input  sfr_pkg::cmp_t                               cmp,
  output logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] hold,
  output logic [sfr_pkg::LEN_W-1:0]                   len,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]                  in_byte,
  input  logic                                        in_last,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output sfr_pkg::result_t                            out_res,
  output logic                                        out_run_last,
  output logic                                        out_end
);

  sfr_pkg::state_t state, state_next;

  logic                             last;
  logic [sfr_pkg::REP_IDX_W-1:0]    ridx;
  logic [sfr_pkg::CNT_W-1:0]        count;
  logic                             pend_valid;
  sfr_pkg::result_t                 pend;

  logic                             accept;
  logic                             out_free;
  logic                             can_put;
  logic                             put_new;
  logic [sfr_pkg::BYTE_W-1:0]       new_data;
  logic                             shift;
  logic                             bump;
  logic                             clear_len;
  logic                             ridx_inc;
  logic                             fin_go;
  logic                             fin_push;
  logic                             rep_end;
  logic [sfr_pkg::LEN_W-1:0]        start;

  assign s_tready = (state == sfr_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  // a new result moves the one-deep lookahead into the output register
  assign can_put  = !pend_valid || out_free;
  assign rep_end  = (sfr_pkg::LEN_W'(ridx) + sfr_pkg::LEN_W'(1)) == cfg.rlen;
  assign start    = ((len > cfg.plen) || (len >= sfr_pkg::LEN_W'(MAX_PATTERN))) ?
                    '0 : len;

  always_comb begin
    state_next = state;
    unique case (state)
      sfr_pkg::ST_IDLE: begin
        if (accept) state_next = sfr_pkg::ST_CHECK;
      end
      sfr_pkg::ST_CHECK: begin
        if (cmp.full) begin
          state_next = (cfg.rlen != '0) ? sfr_pkg::ST_REP : sfr_pkg::ST_DONE;
        end else if (cmp.match) begin
          state_next = last ? sfr_pkg::ST_FLUSH : sfr_pkg::ST_DONE;
        end else if (can_put && (len == sfr_pkg::LEN_W'(1))) begin
          state_next = sfr_pkg::ST_DONE;
        end
      end
      sfr_pkg::ST_REP: begin
        if (can_put && rep_end) state_next = sfr_pkg::ST_DONE;
      end
      sfr_pkg::ST_FLUSH: begin
        if (can_put && (len == sfr_pkg::LEN_W'(1))) state_next = sfr_pkg::ST_DONE;
      end
      sfr_pkg::ST_DONE: begin
        if (fin_go) state_next = sfr_pkg::ST_IDLE;
      end
      default: state_next = sfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    put_new   = 1'b0;
    new_data  = hold[0];
    shift     = 1'b0;
    bump      = 1'b0;
    clear_len = 1'b0;
    ridx_inc  = 1'b0;
    fin_push  = pend_valid || last;
    fin_go    = 1'b0;
    unique case (state)
      sfr_pkg::ST_IDLE: ;
      sfr_pkg::ST_CHECK: begin
        if (cmp.full) begin
          bump      = 1'b1;
          clear_len = 1'b1;
        end else if (!cmp.match && can_put) begin
          put_new = 1'b1;
          shift   = 1'b1;
        end
      end
      sfr_pkg::ST_REP: begin
        new_data = cfg.rep[{ridx, 3'b000} +: sfr_pkg::BYTE_W];
        put_new  = can_put;
        ridx_inc = can_put;
      end
      sfr_pkg::ST_FLUSH: begin
        put_new = can_put;
        shift   = can_put;
      end
      sfr_pkg::ST_DONE: begin
        fin_go = fin_push ? out_free : 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sfr_pkg::ST_IDLE;
      len        <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (fin_go && fin_push) begin
        m_tvalid <= 1'b1;
      end else if (put_new && pend_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (state == sfr_pkg::ST_IDLE) begin
        if (cfg.pat_clear) begin
          len <= '0;
        end else if (accept) begin
          len <= start + sfr_pkg::LEN_W'(1);
        end
      end else if (clear_len) begin
        len <= '0;
      end else if (shift) begin
        len <= len - sfr_pkg::LEN_W'(1);
      end

      if (bump && (count != sfr_pkg::CNT_MAX)) count <= count + sfr_pkg::CNT_W'(1);

      if (put_new) pend_valid <= 1'b1;

      if (fin_go) begin
        pend_valid <= 1'b0;
        if (last) count <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last <= in_last;
      ridx <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (sfr_pkg::LEN_W'(i) == start) hold[i] <= in_byte;
      end
    end else begin
      if (ridx_inc) ridx <= ridx + sfr_pkg::REP_IDX_W'(1);
      if (shift) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) hold[i] <= hold[i+1];
      end
    end

    if (put_new) begin
      pend.data   <= new_data;
      pend.bvalid <= 1'b1;
      pend.count  <= count;
      if (pend_valid) begin
        out_res      <= pend;
        out_run_last <= 1'b0;
        out_end      <= 1'b0;
      end
    end

    if (fin_go && fin_push) begin
      out_run_last <= 1'b1;
      out_end      <= last;
      if (pend_valid) begin
        out_res <= pend;
      end else begin
        // text ended without any byte to emit: bare end mark
        out_res.data   <= '0;
        out_res.bvalid <= 1'b0;
        out_res.count  <= count;
      end
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == sfr_pkg::ST_IDLE) |-> !pend_valid)
    else $error("pending result left behind at end of item");

  a_work_has_bytes: assert property (@(posedge clk) disable iff (rst)
    ((state == sfr_pkg::ST_CHECK) || (state == sfr_pkg::ST_FLUSH)) |-> (len != '0))
    else $error("comparison or flush with nothing held");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fin_go && last) |=> ((count == '0) && (len == '0)))
    else $error("state not cleared after end of text");

  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.bvalid) |-> (out_end && out_run_last))
    else $error("bare end mark not flagged as end of text");

endmodule

FILE: sim/sfr_replace_tracker_pkg.sv
// ----------------------------------------------------------------------------
// sfr_replace_tracker_pkg
// Scoreboard for the stream find-and-replace core: it follows the pattern and
// replacement registers, predicts the output items of every accepted text
// byte and checks each output item against the oldest prediction.
// ----------------------------------------------------------------------------
package sfr_replace_tracker_pkg;

  typedef struct {
    logic [7:0]  data;
    logic        bvalid;
    logic        run_last;
    logic        stream_end;
    logic [15:0] count;
  } text_out_t;

  class replace_tracker;
    logic [3:0]  pat_len;
    logic [63:0] pat_word;
    logic [3:0]  rep_len;
    logic [63:0] rep_word;
    logic [7:0]  held [0:7];
    int          held_cnt;
    logic [15:0] match_cnt;
    text_out_t   step_out [$];
    text_out_t   pending_out [$];
    int          errors;

    function new();
      pat_len   = '0;
      pat_word  = '0;
      rep_len   = '0;
      rep_word  = '0;
      held_cnt  = 0;
      match_cnt = '0;
      errors    = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function int pending();
      return pending_out.size();
    endfunction

    function int active_pattern_len();
      return (pat_len > 4'd8) ? 8 : int'(pat_len);
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] value);
      case (idx)
        sfr_pkg::REG_PATTERN_LENGTH: begin
          pat_len  = value[3:0];
          held_cnt = 0;
        end
        sfr_pkg::REG_PATTERN_BYTES: begin
          pat_word = value;
          held_cnt = 0;
        end
        sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  rep_word = value;
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] b, logic v);
      text_out_t r;
      r.data       = b;
      r.bvalid     = v;
      r.run_last   = 1'b0;
      r.stream_end = 1'b0;
      r.count      = match_cnt;
      step_out.push_back(r);
    endfunction

    // one accepted text byte: held prefix plus the new byte, rechecked
    function void take_byte(logic [7:0] b, logic last);
      logic [7:0] win [0:8];
      text_out_t  r;
      int         pl;
      int         rl;
      int         len;
      int         i;
      logic       hit;
      pl = active_pattern_len();
      rl = (rep_len > 4'd8) ? 8 : int'(rep_len);
      step_out.delete();
      if (held_cnt > pl || held_cnt >= 8) held_cnt = 0;
      len = 0;
      for (i = 0; i < held_cnt; i++) begin
        win[len] = held[i];
        len++;
      end
      win[len] = b;
      len++;
      while (len > 0) begin
        hit = (pl > 0) && (len <= pl);
        for (i = 0; hit && i < len; i++)
          if (win[i] != pat_word[8*i +: 8]) hit = 1'b0;
        if (hit && len == pl) begin
          if (match_cnt != sfr_pkg::CNT_MAX) match_cnt++;
          for (i = 0; i < rl; i++) emit(rep_word[8*i +: 8], 1'b1);
          len = 0;
        end else if (hit) begin
          break;
        end else begin
          // oldest byte cannot start a match, pass it on and slide
          emit(win[0], 1'b1);
          for (i = 0; i < len - 1; i++) win[i] = win[i+1];
          len--;
        end
      end
      if (last) begin
        for (i = 0; i < len; i++) emit(win[i], 1'b1);
        len = 0;
        if (step_out.size() == 0) emit(8'h00, 1'b0);
        r = step_out.pop_back();
        r.stream_end = 1'b1;
        step_out.push_back(r);
      end
      if (step_out.size() > 0) begin
        r = step_out.pop_back();
        r.run_last = 1'b1;
        step_out.push_back(r);
      end
      held_cnt = len;
      for (i = 0; i < len; i++) held[i] = win[i];
      if (last) match_cnt = '0;
      foreach (step_out[k]) pending_out.push_back(step_out[k]);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_output(logic [31:0] tdata, logic tuser, logic tlast);
      text_out_t want;
      if (pending_out.size() == 0) begin
        $error("unexpected item: tdata %0h tuser %b tlast %b", tdata, tuser, tlast);
        errors++;
        return;
      end
      want = pending_out.pop_front();
      check_field("out_byte", 32'(want.data), 32'(tdata[7:0]));
      check_field("run_last", 32'(want.run_last), 32'(tdata[8]));
      check_field("replace_count", 32'(want.count), 32'(tdata[24:9]));
      check_field("tdata_pad", 32'd0, 32'(tdata[31:25]));
      check_field("byte_valid", 32'(want.bvalid), 32'(tuser));
      check_field("stream_end", 32'(want.stream_end), 32'(tlast));
    endfunction
  endclass

endpackage

FILE: sim/tb_stream_find_replace_core.sv
// ----------------------------------------------------------------------------
// tb_stream_find_replace_core
// Drives text streams and register settings into the find-and-replace core,
// with random idle bursts on both stream sides, and checks every output item
// against a scoreboard prediction; ends with a stretch without idling.
// ----------------------------------------------------------------------------
module tb_stream_find_replace_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 360;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] in_byte
  logic        s_tlast = 1'b0; // in_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [7:0] out_byte, [8] run_last, [24:9] replace_count
  logic        m_tuser;        // byte_valid
  logic        m_tlast;        // stream_end

  bit idle_on = 1'b1;
  int sent_items = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  sfr_replace_tracker_pkg::replace_tracker tracker = new();

  always #1 clk = ~clk;

  stream_find_replace_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // output side: check accepted items, stall in bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_output(m_tdata, m_tuser, m_tlast);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(b, last);
    sent_items++;
  endtask

  // wait for all predicted items, then give held work time to finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [7:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, value);
  endtask

  task automatic configure(input logic [63:0] plen, input logic [63:0] pword,
                           input logic [63:0] rlen, input logic [63:0] rword);
    settle();
    set_reg(sfr_pkg::REG_PATTERN_LENGTH, plen);
    set_reg(sfr_pkg::REG_PATTERN_BYTES, pword);
    set_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, rlen);
    set_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rword);
    cfg_valid <= 1'b0;
  endtask

  // length word: random upper bits, low nibble 0, 1..8 or oversized
  function automatic logic [63:0] random_len();
    logic [63:0] w;
    int          k;
    w = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (k == 0) w[3:0] = 4'd0;
    else if (k == 1) w[3:0] = 4'($urandom_range(9, 15));
    else w[3:0] = 4'($urandom_range(1, 8));
    return w;
  endfunction

  // narrow words use two letters only, so patterns overlap themselves
  function automatic logic [63:0] random_word(input bit narrow);
    logic [63:0] w;
    int          j;
    w = {$urandom, $urandom};
    if (narrow)
      for (j = 0; j < 8; j++) w[8*j +: 8] = 8'h61 + 8'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [7:0] noise_byte(input int pl);
    if (pl > 0 && $urandom_range(0, 1) == 0)
      return tracker.pat_word[8*$urandom_range(0, pl-1) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  // text built mostly from whole patterns and broken prefixes
  task automatic send_text(input int n, input logic close);
    logic [7:0] text_q [$];
    int         pl;
    int         k;
    int         j;
    int         cut;
    pl = tracker.active_pattern_len();
    while (text_q.size() < n) begin
      k = $urandom_range(0, 9);
      if (pl > 0 && k < 4) begin
        for (j = 0; j < pl; j++) text_q.push_back(tracker.pat_word[8*j +: 8]);
      end else if (pl > 1 && k < 7) begin
        cut = $urandom_range(1, pl-1);
        for (j = 0; j < cut; j++) text_q.push_back(tracker.pat_word[8*j +: 8]);
        text_q.push_back(noise_byte(pl));
      end else begin
        text_q.push_back(noise_byte(pl));
      end
    end
    for (j = 0; j < n; j++) send_byte(text_q[j], close && j == n - 1);
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty pattern after reset: bytes pass through
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);

    // pattern "ab" -> "XYZ": match, mismatch with recheck, flush at end
    configure(64'hA5A5_0000_0000_0002, 64'hDEAD_BEEF_0000_6261,
              64'h0000_0000_0000_0003, 64'h0000_0000_005A_5958);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h78, 1'b1);

    // pattern rewritten while a prefix is held
    send_byte(8'h61, 1'b0);
    settle();
    set_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0000_6261);
    cfg_valid <= 1'b0;
    send_byte(8'h62, 1'b1);

    // oversized lengths clamp to eight bytes
    configure(64'h0000_0000_0000_0009, 64'h0807_0605_0403_0201,
              64'h0000_0000_0000_000F, 64'hFFEE_DDCC_BBAA_9988);
    for (i = 1; i <= 8; i++) send_byte(8'(i), i == 8);

    // empty replacement deletes; match on the last byte gives a bare end mark
    configure(64'h1, 64'hFF, 64'h0, 64'h0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();
    set_reg(8'hFF, '1);
    cfg_valid <= 1'b0;
    send_byte(8'hFF, 1'b1);

    while (sent_items < RANDOM_ITEMS) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      configure(random_len(), random_word($urandom_range(0, 1)), random_len(),
                random_word(1'b0));
      repeat ($urandom_range(1, 3))
        send_text($urandom_range(1, 30), $urandom_range(0, 4) != 0);
    end

    // no idling from here on
    idle_on <= 1'b0;
    configure(random_len(), random_word(1'b1), random_len(), random_word(1'b0));
    send_text(40, 1'b1);
    settle();

    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
